// ===== rtl/rsi_pkg.sv =====
// rsi_pkg: shared constants, command and status types for the rsi core
// used by every module under rtl; depends on nothing else
`timescale 1ns / 1ps

package rsi_pkg;

	localparam int PRICE_BITS_DEF = 24;
	localparam int PERIOD_MAX     = 255;

	localparam int PERIOD_W = 8;
	localparam int CNT_W    = 9;
	localparam int AVG_W    = 64;
	localparam int AVG_FRAC = 16;
	localparam int NORM_BIT = 48;
	localparam int DVD_W    = 80;
	localparam int DVS_W    = 49;
	localparam int QUO_W    = 64;
	localparam int ITER_W   = 7;
	localparam int RSI_W    = 15;
	localparam int PROD_W   = 63;

	localparam logic [PERIOD_W-1:0] PERIOD_CAP = PERIOD_W'(PERIOD_MAX > 255 ? 255 : PERIOD_MAX);
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 8'd14;

	localparam logic [RSI_W-1:0] RSI_FULL    = 15'd25600;
	localparam logic [RSI_W-1:0] RSI_NO_LOSS = 15'd25346;

	localparam logic [ITER_W-1:0] ITER_SEED = 7'd80;
	localparam logic [ITER_W-1:0] ITER_STD  = 7'd64;

	typedef enum logic [1:0] {
		SEL_GAIN,
		SEL_LOSS,
		SEL_RSI
	} rsi_sel_t;

	typedef struct packed {
		logic     load;
		logic     prep;
		logic     div_start;
		rsi_sel_t div_sel;
		logic     div_apply;
		logic     norm_load;
		logic     norm_shift;
		logic     mul;
		logic     res_none;
		logic     res_noloss;
		logic     out_load;
	} rsi_cmd_t;

	typedef struct packed {
		logic no_value;
		logic div_done;
		logic norm_big;
		logic loss_zero;
		logic out_busy;
	} rsi_sts_t;

endpackage

// ===== rtl/rsi_div.sv =====
// rsi_div: shared restoring divider, one quotient bit per cycle
// depends on rsi_pkg for widths
`timescale 1ns / 1ps

module rsi_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rsi_pkg::DVD_W-1:0]  dividend,
	input  logic [rsi_pkg::DVS_W-1:0]  divisor,
	input  logic [rsi_pkg::ITER_W-1:0] iters,
	output logic                       done,
	output logic [rsi_pkg::QUO_W-1:0]  quotient
);

	logic [rsi_pkg::DVD_W-1:0]  dq_q;
	logic [rsi_pkg::DVS_W-1:0]  rem_q;
	logic [rsi_pkg::DVS_W-1:0]  dvs_q;
	logic [rsi_pkg::ITER_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [rsi_pkg::DVS_W:0]    trial;
	logic [rsi_pkg::DVS_W:0]    diff;
	logic                       fits;

	assign trial = {rem_q, dq_q[rsi_pkg::DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rsi_pkg::ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in at the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[rsi_pkg::DVD_W-2:0], fits};
			rem_q <= fits ? diff[rsi_pkg::DVS_W-1:0] : trial[rsi_pkg::DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dq_q[rsi_pkg::QUO_W-1:0];

endmodule

// ===== rtl/rsi_dp.sv =====
// rsi_dp: series state, period register, averaging and rsi datapath
// depends on rsi_pkg and rsi_div; driven by rsi_ctrl commands
`timescale 1ns / 1ps

module rsi_dp #(
	parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rsi_pkg::PERIOD_W-1:0] cfg_data,
	input  logic [PRICE_BITS-1:0]        price,
	input  logic                         start_series,
	input  logic                         out_ready,
	input  rsi_pkg::rsi_cmd_t            cmd,
	output rsi_pkg::rsi_sts_t            sts,
	output logic                         out_valid,
	output logic [rsi_pkg::RSI_W-1:0]    rsi_value,
	output logic                         valid_res
);

	logic [rsi_pkg::PERIOD_W-1:0] period_q;
	logic [PRICE_BITS-1:0]        price_q;
	logic [PRICE_BITS-1:0]        prev_q;
	logic [PRICE_BITS-1:0]        up_q;
	logic [PRICE_BITS-1:0]        dn_q;
	logic [rsi_pkg::AVG_W-1:0]    gain_q;
	logic [rsi_pkg::AVG_W-1:0]    loss_q;
	logic [rsi_pkg::CNT_W-1:0]    cnt_q;
	logic                         seed_q;
	logic [rsi_pkg::AVG_W-1:0]    wg_q;
	logic [rsi_pkg::AVG_W-1:0]    wl_q;
	logic [rsi_pkg::PROD_W-1:0]   prod_q;
	logic [rsi_pkg::DVS_W-1:0]    sum_q;
	logic [rsi_pkg::RSI_W-1:0]    res_q;
	logic                         res_valid_q;
	logic                         out_valid_q;
	logic [rsi_pkg::RSI_W-1:0]    rsi_q;
	logic                         vres_q;

	logic [rsi_pkg::PERIOD_W-1:0] eff_p;
	logic [rsi_pkg::CNT_W-1:0]    p9;
	logic                         rising;
	logic [PRICE_BITS-1:0]        up;
	logic [PRICE_BITS-1:0]        dn;
	logic                         seed_acc;
	logic [rsi_pkg::AVG_W-1:0]    cur_avg;
	logic [rsi_pkg::AVG_W-1:0]    cur_x;
	logic                         x_ge;
	logic [rsi_pkg::AVG_W-1:0]    wdiff;
	logic [rsi_pkg::AVG_W-1:0]    smoothed;
	logic [rsi_pkg::AVG_W-1:0]    new_avg;
	logic [rsi_pkg::DVD_W-1:0]    dividend;
	logic [rsi_pkg::DVS_W-1:0]    divisor;
	logic [rsi_pkg::ITER_W-1:0]   iters;
	logic                         div_done;
	logic [rsi_pkg::QUO_W-1:0]    quotient;

	// period zero acts as one, values above the cap are clipped
	always_comb begin
		if (period_q == '0)
			eff_p = rsi_pkg::PERIOD_W'(1);
		else if (period_q > rsi_pkg::PERIOD_CAP)
			eff_p = rsi_pkg::PERIOD_CAP;
		else
			eff_p = period_q;
	end

	assign p9       = rsi_pkg::CNT_W'(eff_p);
	assign rising   = price_q > prev_q;
	assign up       = rising ? price_q - prev_q : '0;
	assign dn       = rising ? '0 : prev_q - price_q;
	assign seed_acc = (cnt_q != '0) && (cnt_q <= p9);

	assign cur_avg  = (cmd.div_sel == rsi_pkg::SEL_LOSS) ? loss_q : gain_q;
	assign cur_x    = (cmd.div_sel == rsi_pkg::SEL_LOSS) ?
	                  (rsi_pkg::AVG_W'(dn_q) << rsi_pkg::AVG_FRAC) :
	                  (rsi_pkg::AVG_W'(up_q) << rsi_pkg::AVG_FRAC);
	assign x_ge     = cur_x >= cur_avg;
	assign wdiff    = x_ge ? cur_x - cur_avg : cur_avg - cur_x;
	assign smoothed = x_ge ? cur_avg + quotient : cur_avg - quotient;
	assign new_avg  = seed_q ? quotient : smoothed;

	// every operand sits above 16 zero bits; the seed pass runs all 80 bits
	always_comb begin
		unique case (cmd.div_sel)
			rsi_pkg::SEL_RSI: begin
				dividend = rsi_pkg::DVD_W'({prod_q, {rsi_pkg::AVG_FRAC{1'b0}}});
				divisor  = sum_q;
				iters    = rsi_pkg::ITER_STD;
			end
			rsi_pkg::SEL_GAIN, rsi_pkg::SEL_LOSS: begin
				dividend = seed_q ? {cur_avg, {rsi_pkg::AVG_FRAC{1'b0}}} :
				                    {wdiff, {rsi_pkg::AVG_FRAC{1'b0}}};
				divisor  = rsi_pkg::DVS_W'(eff_p);
				iters    = seed_q ? rsi_pkg::ITER_SEED : rsi_pkg::ITER_STD;
			end
			default: begin
				dividend = '0;
				divisor  = rsi_pkg::DVS_W'(eff_p);
				iters    = rsi_pkg::ITER_STD;
			end
		endcase
	end

	rsi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.iters    (iters),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= rsi_pkg::PERIOD_RST;
		end else if (cfg_we) begin
			period_q <= cfg_data;
		end
	end

	// series state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			gain_q <= '0;
			loss_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.load) begin
			if (start_series) begin
				prev_q <= '0;
				gain_q <= '0;
				loss_q <= '0;
				cnt_q  <= '0;
			end
		end else if (cmd.prep) begin
			prev_q <= price_q;
			if (seed_acc) begin
				gain_q <= gain_q + rsi_pkg::AVG_W'(up);
				loss_q <= loss_q + rsi_pkg::AVG_W'(dn);
			end
			if (cnt_q < p9 + rsi_pkg::CNT_W'(1))
				cnt_q <= cnt_q + 1'b1;
		end else if (cmd.div_apply) begin
			if (cmd.div_sel == rsi_pkg::SEL_GAIN)
				gain_q <= new_avg;
			else if (cmd.div_sel == rsi_pkg::SEL_LOSS)
				loss_q <= new_avg;
		end
	end

	// working registers for one request
	always_ff @(posedge clk) begin
		if (cmd.load)
			price_q <= price;
		if (cmd.prep) begin
			up_q   <= up;
			dn_q   <= dn;
			seed_q <= cnt_q == p9;
		end
		if (cmd.norm_load) begin
			wg_q <= gain_q;
			wl_q <= loss_q;
		end else if (cmd.norm_shift) begin
			wg_q <= wg_q >> 1;
			wl_q <= wl_q >> 1;
		end
		if (cmd.mul) begin
			prod_q <= rsi_pkg::PROD_W'(rsi_pkg::RSI_FULL) *
			          rsi_pkg::PROD_W'(wg_q[rsi_pkg::NORM_BIT-1:0]);
			sum_q  <= rsi_pkg::DVS_W'(wg_q[rsi_pkg::NORM_BIT-1:0]) +
			          rsi_pkg::DVS_W'(wl_q[rsi_pkg::NORM_BIT-1:0]);
		end
		if (cmd.res_none) begin
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else if (cmd.res_noloss) begin
			res_q       <= rsi_pkg::RSI_NO_LOSS;
			res_valid_q <= 1'b1;
		end else if (cmd.div_apply && cmd.div_sel == rsi_pkg::SEL_RSI) begin
			res_q       <= quotient[rsi_pkg::RSI_W-1:0];
			res_valid_q <= 1'b1;
		end
		if (cmd.out_load) begin
			rsi_q  <= res_q;
			vres_q <= res_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.no_value  = (cnt_q == '0) || (cnt_q < p9);
	assign sts.div_done  = div_done;
	assign sts.norm_big  = (|wg_q[rsi_pkg::AVG_W-1:rsi_pkg::NORM_BIT]) ||
	                       (|wl_q[rsi_pkg::AVG_W-1:rsi_pkg::NORM_BIT]);
	assign sts.loss_zero = wl_q == '0;
	assign sts.out_busy  = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign rsi_value = rsi_q;
	assign valid_res = vres_q;

endmodule

// ===== rtl/rsi_ctrl.sv =====
// rsi_ctrl: sequencer that steps one price bar through the datapath
// depends on rsi_pkg command and status types
`timescale 1ns / 1ps

module rsi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  rsi_pkg::rsi_sts_t sts,
	output logic              in_ready,
	output rsi_pkg::rsi_cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PREP   = 4'd1;
	localparam logic [3:0] S_GSTART = 4'd2;
	localparam logic [3:0] S_GWAIT  = 4'd3;
	localparam logic [3:0] S_LSTART = 4'd4;
	localparam logic [3:0] S_LWAIT  = 4'd5;
	localparam logic [3:0] S_NLOAD  = 4'd6;
	localparam logic [3:0] S_NORM   = 4'd7;
	localparam logic [3:0] S_RSTART = 4'd8;
	localparam logic [3:0] S_RWAIT  = 4'd9;
	localparam logic [3:0] S_OUT    = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				if (sts.no_value) begin
					cmd.res_none = 1'b1;
					state_nxt    = S_OUT;
				end else begin
					state_nxt = S_GSTART;
				end
			end
			S_GSTART: begin
				cmd.div_sel   = rsi_pkg::SEL_GAIN;
				cmd.div_start = 1'b1;
				state_nxt     = S_GWAIT;
			end
			S_GWAIT: begin
				cmd.div_sel = rsi_pkg::SEL_GAIN;
				if (sts.div_done) begin
					cmd.div_apply = 1'b1;
					state_nxt     = S_LSTART;
				end
			end
			S_LSTART: begin
				cmd.div_sel   = rsi_pkg::SEL_LOSS;
				cmd.div_start = 1'b1;
				state_nxt     = S_LWAIT;
			end
			S_LWAIT: begin
				cmd.div_sel = rsi_pkg::SEL_LOSS;
				if (sts.div_done) begin
					cmd.div_apply = 1'b1;
					state_nxt     = S_NLOAD;
				end
			end
			S_NLOAD: begin
				cmd.norm_load = 1'b1;
				state_nxt     = S_NORM;
			end
			S_NORM: begin
				// halve both averages together until they fit the divider
				if (sts.norm_big) begin
					cmd.norm_shift = 1'b1;
				end else if (sts.loss_zero) begin
					cmd.res_noloss = 1'b1;
					state_nxt      = S_OUT;
				end else begin
					cmd.mul   = 1'b1;
					state_nxt = S_RSTART;
				end
			end
			S_RSTART: begin
				cmd.div_sel   = rsi_pkg::SEL_RSI;
				cmd.div_start = 1'b1;
				state_nxt     = S_RWAIT;
			end
			S_RWAIT: begin
				cmd.div_sel = rsi_pkg::SEL_RSI;
				if (sts.div_done) begin
					cmd.div_apply = 1'b1;
					state_nxt     = S_OUT;
				end
			end
			S_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/relative_strength_index_core.sv =====
// relative_strength_index_core: rsi with wilder smoothing, one price bar per request
// depends on rsi_pkg, rsi_ctrl, rsi_dp (which holds rsi_div)
//
//   port group   direction  handshake             payload
//   cfg          in         cfg_we                cfg_data (period)
//   in           in         in_valid / in_ready   price, start_series
//   out          out        out_valid / out_ready rsi_value, valid_res
//
// a bar before the window closes goes from prep straight to output; any other bar
// runs the gain and loss divisions, up to 16 normalizing shifts and the rsi division,
// and the seeding bar divides over the full dividend width; a zero loss average skips
// the last division; the shared divider produces one quotient bit per cycle
// one request is in flight at a time; the next is taken while a result waits in the
// output register
// arst_n clears the period to 14 and the series state to zero
`timescale 1ns / 1ps

module relative_strength_index_core #(
	parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rsi_pkg::PERIOD_W-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [PRICE_BITS-1:0]        price,
	input  logic                         start_series,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rsi_pkg::RSI_W-1:0]    rsi_value,
	output logic                         valid_res
);

	rsi_pkg::rsi_cmd_t cmd;
	rsi_pkg::rsi_sts_t sts;

	rsi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	rsi_dp #(
		.PRICE_BITS (PRICE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.price        (price),
		.start_series (start_series),
		.out_ready    (out_ready),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.rsi_value    (rsi_value),
		.valid_res    (valid_res)
	);

endmodule

// ===== rtl/rsi_checker.sv =====
// rsi_checker: port-level checks on the rsi core, attached by bind
// depends on rsi_pkg and relative_strength_index_core
`timescale 1ns / 1ps

module rsi_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [rsi_pkg::RSI_W-1:0] rsi_value,
	input logic                      valid_res
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rsi_value) && $stable(valid_res))
		else $error("result changed while stalled");

	// a bar without a value reports zero
	a_no_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> rsi_value == '0)
		else $error("invalid result with nonzero value");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rsi_value <= rsi_pkg::RSI_FULL)
		else $error("rsi above full scale");

	// one request at a time: an accepted bar closes the input
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input reopened right after a request");

endmodule

bind relative_strength_index_core rsi_checker u_rsi_checker (.*);

// ===== dv/tb_relative_strength_index_core.sv =====
// tb_relative_strength_index_core: self-checking bench for the rsi core, random price
// series under valid/ready idling with a scoreboard that predicts wilder smoothed rsi
// depends on rtl/rsi_pkg.sv and rtl/relative_strength_index_core.sv
`timescale 1ns / 1ps

module tb_relative_strength_index_core;

	localparam int PX_W           = rsi_pkg::PRICE_BITS_DEF;
	localparam int PX_MAX         = (1 << PX_W) - 1;
	localparam int MODE_BARS      = 330;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RX_HOLD_CYCLES = 800;
	localparam int END_WAIT       = 300;

	typedef enum int {
		PS_WALK,
		PS_JUMP,
		PS_RISE,
		PS_FALL,
		PS_FLAT,
		PS_SWING
	} price_style_t;

	typedef struct {
		logic [rsi_pkg::RSI_W-1:0] rsi;
		logic                      valid;
	} rsi_result_t;

	class rsi_scoreboard;
		bit [rsi_pkg::PERIOD_W-1:0] period_reg = rsi_pkg::PERIOD_RST;
		bit [PX_W-1:0]              last_price;
		bit [63:0]                  gain_acc;
		bit [63:0]                  loss_acc;
		bit [rsi_pkg::CNT_W-1:0]    bar_idx;
		rsi_result_t                expected_q[$];
		int                         mismatches;
		int                         checked;
		int                         rsi_seen;
		int                         noloss_seen;
		int                         zero_seen;

		// floor(sum * 2^frac / p) without a wide intermediate
		function bit [63:0] seed_average(bit [63:0] sum, bit [63:0] p);
			return ((sum / p) << rsi_pkg::AVG_FRAC) +
			       (((sum % p) << rsi_pkg::AVG_FRAC) / p);
		endfunction

		// avg += (x - avg) / p, truncating toward zero
		function bit [63:0] smooth_average(bit [63:0] avg, bit [63:0] x, bit [63:0] p);
			if (x >= avg)
				return avg + (x - avg) / p;
			return avg - (avg - x) / p;
		endfunction

		function bit [rsi_pkg::RSI_W-1:0] rsi_ratio(bit [63:0] g, bit [63:0] l);
			bit [63:0] q;
			if (l == 0)
				return rsi_pkg::RSI_NO_LOSS;
			while (g >= (64'd1 << rsi_pkg::NORM_BIT) || l >= (64'd1 << rsi_pkg::NORM_BIT)) begin
				g = g >> 1;
				l = l >> 1;
			end
			if (l == 0)
				return rsi_pkg::RSI_NO_LOSS;
			q = (64'(rsi_pkg::RSI_FULL) * g) / (g + l);
			return q[rsi_pkg::RSI_W-1:0];
		endfunction

		function void note_bar(bit [PX_W-1:0] px, bit st);
			bit [63:0]               p;
			bit [63:0]               up;
			bit [63:0]               dn;
			bit [rsi_pkg::CNT_W-1:0] idx;
			rsi_result_t             r;
			p = (period_reg == 0) ? 64'd1 : 64'(period_reg);
			if (p > 64'(rsi_pkg::PERIOD_MAX))
				p = 64'(rsi_pkg::PERIOD_MAX);
			up = 0;
			dn = 0;
			r.rsi = '0;
			r.valid = 1'b0;
			if (st) begin
				last_price = '0;
				gain_acc = '0;
				loss_acc = '0;
				bar_idx = '0;
			end
			idx = bar_idx;
			if (idx != 0) begin
				if (px > last_price)
					up = px - last_price;
				else
					dn = last_price - px;
				if (idx <= p) begin
					gain_acc += up;
					loss_acc += dn;
					if (idx == p) begin
						gain_acc = seed_average(gain_acc, p);
						loss_acc = seed_average(loss_acc, p);
						r.valid = 1'b1;
					end
				end else begin
					gain_acc = smooth_average(gain_acc, up << rsi_pkg::AVG_FRAC, p);
					loss_acc = smooth_average(loss_acc, dn << rsi_pkg::AVG_FRAC, p);
					r.valid = 1'b1;
				end
			end
			last_price = px;
			if (bar_idx < p + 1)
				bar_idx++;
			if (r.valid)
				r.rsi = rsi_ratio(gain_acc, loss_acc);
			expected_q.push_back(r);
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("%0t mismatch: %s", $time, msg);
		endtask

		task check_result(logic [rsi_pkg::RSI_W-1:0] rsi, logic vld);
			rsi_result_t e;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result rsi=%0d valid=%0b with no request pending",
					rsi, vld));
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (vld !== e.valid)
				report_mismatch($sformatf("result %0d valid_res got %0b want %0b",
					checked, vld, e.valid));
			if (rsi !== e.rsi)
				report_mismatch($sformatf("result %0d rsi_value got %0d want %0d",
					checked, rsi, e.rsi));
			if (e.valid) begin
				rsi_seen++;
				if (e.rsi == rsi_pkg::RSI_NO_LOSS)
					noloss_seen++;
				if (e.rsi == 0)
					zero_seen++;
			end
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_we;
	logic [rsi_pkg::PERIOD_W-1:0] cfg_data;
	logic                         in_valid;
	logic                         in_ready;
	logic [PX_W-1:0]              price;
	logic                         start_series;
	logic                         out_valid;
	logic                         out_ready;
	logic [rsi_pkg::RSI_W-1:0]    rsi_value;
	logic                         valid_res;

	rsi_scoreboard sb;
	int            tx_idle_pct = 0;
	int            rx_idle_pct = 0;
	bit            rx_hold_arm;
	bit            rx_hold_used;
	int            rx_hold_left;
	int            quiet_cycles;
	int            bars_sent;
	int            period_writes;
	int            period_lo = 255;
	int            period_hi = 0;

	relative_strength_index_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.price       (price),
		.start_series(start_series),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.rsi_value   (rsi_value),
		.valid_res   (valid_res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random backpressure, plus one long hold-off once armed
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (rx_hold_left != 0) begin
			out_ready <= 1'b0;
			rx_hold_left <= rx_hold_left - 1;
		end else if (rx_hold_arm && !rx_hold_used) begin
			out_ready <= 1'b0;
			rx_hold_used <= 1'b1;
			rx_hold_left <= RX_HOLD_CYCLES;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// result checked before the request of the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(rsi_value, valid_res);
			if (in_valid && in_ready)
				sb.note_bar(price, start_series);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("** relative_strength_index_core: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task set_idling(int tx, int rx);
		tx_idle_pct = tx;
		rx_idle_pct <= rx;
	endtask

	task wait_drained();
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	// period is only written with the core empty
	task write_period(bit [rsi_pkg::PERIOD_W-1:0] value);
		in_valid <= 1'b0;
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_data <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.period_reg = value;
		period_writes++;
		if (value < period_lo)
			period_lo = value;
		if (value > period_hi)
			period_hi = value;
	endtask

	task send_bar(bit [PX_W-1:0] px, bit st);
		if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		price <= px;
		start_series <= st;
		do @(posedge clk); while (!in_ready);
		bars_sent++;
	endtask

	function automatic bit [PX_W-1:0] next_price(bit [PX_W-1:0] cur, price_style_t style);
		longint v;
		v = cur;
		case (style)
			PS_WALK:  v = v + longint'($urandom_range(0, 510)) - 255;
			PS_JUMP:  v = longint'($urandom_range(0, PX_MAX));
			PS_RISE:  v = v + longint'($urandom_range(0, 4096));
			PS_FALL:  v = v - longint'($urandom_range(0, 4096));
			PS_FLAT:  v = cur;
			PS_SWING: v = v + longint'($urandom_range(0, 1 << 21)) - (1 << 20);
			default:  v = cur;
		endcase
		if (v < 0)
			v = 0;
		if (v > PX_MAX)
			v = PX_MAX;
		return v[PX_W-1:0];
	endfunction

	initial begin
		int                         m;
		int                         phase_idx;
		int                         mode_bars;
		int                         n_series;
		int                         len;
		int                         eff;
		bit [rsi_pkg::PERIOD_W-1:0] per;
		bit                         st;
		price_style_t               style;
		bit [PX_W-1:0]              cur;

		sb = new;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		price = '0;
		start_series = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(34, 57);

		// reset period, no start flag: first bar after reset is bar zero
		send_bar(24'h000100, 1'b0);
		send_bar(24'h000200, 1'b0);

		// full-scale rise gives zero loss, then full-scale fall
		write_period(2);
		send_bar(0, 1'b1);
		send_bar(PX_W'(PX_MAX), 1'b0);
		send_bar(PX_W'(PX_MAX), 1'b0);
		send_bar(0, 1'b0);
		send_bar(0, 1'b0);
		send_bar(1, 1'b0);

		// flat series: both averages zero
		send_bar(5, 1'b1);
		send_bar(5, 1'b0);
		send_bar(5, 1'b0);
		send_bar(5, 1'b0);

		// period zero acts as one; loss only gives rsi zero
		write_period(0);
		send_bar(100, 1'b1);
		send_bar(50, 1'b0);
		send_bar(80, 1'b0);
		send_bar(80, 1'b0);

		// period changes mid-series, count left above the new limit
		write_period(255);
		send_bar(PX_W'(PX_MAX), 1'b0);
		write_period(1);
		send_bar(0, 1'b0);
		send_bar(PX_W'(PX_MAX / 2), 1'b0);

		for (m = 0; m < 3; m++) begin
			case (m)
				0:       set_idling(34, 57);
				1:       set_idling(57, 34);
				default: set_idling(0, 0);
			endcase
			mode_bars = 0;
			phase_idx = 0;
			while (mode_bars < MODE_BARS) begin
				if (m == 2 && phase_idx == 0)
					per = 255;
				else if ($urandom_range(0, 99) < 3)
					per = 0;
				else if ($urandom_range(0, 99) < 85)
					per = rsi_pkg::PERIOD_W'($urandom_range(1, 16));
				else
					per = rsi_pkg::PERIOD_W'($urandom_range(17, 40));
				write_period(per);
				if (m == 0 && phase_idx == 1)
					rx_hold_arm <= 1'b1;
				eff = (per == 0) ? 1 : per;
				n_series = (eff > 40) ? 1 : $urandom_range(1, 3);
				for (int s = 0; s < n_series; s++) begin
					// sometimes carry the series over the period change
					st = !(s == 0 && $urandom_range(0, 4) == 0);
					len = eff + ((eff > 40) ? $urandom_range(1, 12) : $urandom_range(1, 24));
					style = price_style_t'($urandom_range(0, 5));
					case ($urandom_range(0, 9))
						0:       cur = 0;
						1:       cur = PX_W'(PX_MAX);
						default: cur = PX_W'($urandom_range(0, PX_MAX));
					endcase
					for (int i = 0; i < len; i++) begin
						send_bar(cur, (i == 0) ? st : ($urandom_range(0, 99) < 2));
						if ($urandom_range(0, 99) < 5)
							style = price_style_t'($urandom_range(0, 5));
						cur = next_price(cur, style);
					end
					mode_bars += len;
				end
				phase_idx++;
			end
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (END_WAIT) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
		$display("summary: %0d bars over %0d period writes (periods %0d to %0d), %0d results",
			bars_sent, period_writes, period_lo, period_hi, sb.checked);
		$display("summary: %0d rsi values, %0d at the no-loss constant, %0d at zero",
			sb.rsi_seen, sb.noloss_seen, sb.zero_seen);
		if (sb.mismatches == 0)
			$display("** relative_strength_index_core: PASSED **");
		else
			$display("** relative_strength_index_core: FAILED **");
		$finish;
	end

endmodule
